>>> rtl/aabt_pkg.sv
package aabt_pkg;

    localparam int unsigned ADDR_W  = 128;
    localparam int unsigned TIMER_W = 16;
    localparam int unsigned CFG_AW  = 3;
    localparam int unsigned CFG_DW  = 32;
    localparam int unsigned OUT_DW  = 24;

    localparam logic [TIMER_W-1:0] BLOCK_TICKS_RST = 16'd600;

    localparam logic FUNC_TICK   = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    localparam logic REG_BLOCK_TICKS = 1'b0;

    typedef struct packed {
        logic capture;
        logic rd_en;
        logic ev_en;
        logic ev_first;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic is_lookup;
        logic out_free;
    } sts_t;

endpackage

>>> rtl/aabt_ctrl.sv
module aabt_ctrl
    import aabt_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  sts_t                              sts,
    output cmd_t                              cmd,
    output logic [$clog2(TABLE_ENTRIES)-1:0]  rd_idx,
    output logic [$clog2(TABLE_ENTRIES)-1:0]  ev_idx
);

    localparam int unsigned IW = $clog2(TABLE_ENTRIES);
    localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] LAST_CNT = CW'(TABLE_ENTRIES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ev_reg, ev_next;
    logic [IW-1:0] ev_idx_reg;
    logic          accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign rd_idx   = cnt_reg[IW-1:0];
    assign ev_idx   = ev_idx_reg;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd.capture  = 1'b0;
        cmd.rd_en    = 1'b0;
        cmd.ev_en    = ev_reg;
        cmd.ev_first = ev_reg && (ev_idx_reg == '0);
        cmd.commit   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.capture = 1'b1;
                    cnt_next    = '0;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (cnt_reg != LAST_CNT) begin
                    cmd.rd_en = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end else if (sts.is_lookup) begin
                    state_next = S_FIN;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_FIN: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign ev_next = cmd.rd_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ev_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ev_reg    <= ev_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            ev_idx_reg <= rd_idx;
        end
    end

endmodule

>>> rtl/aabt_dp.sv
module aabt_dp
    import aabt_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [ADDR_W-1:0]                 s_tdata,
    input  logic                              s_tuser,
    input  logic [TIMER_W-1:0]                block_ticks,
    input  cmd_t                              cmd,
    input  logic [$clog2(TABLE_ENTRIES)-1:0]  rd_idx,
    input  logic [$clog2(TABLE_ENTRIES)-1:0]  ev_idx,
    output sts_t                              sts,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [OUT_DW-1:0]                 m_tdata
);

    localparam int unsigned IW = $clog2(TABLE_ENTRIES);

    logic [ADDR_W-1:0]  key_mem [TABLE_ENTRIES];
    logic [TIMER_W-1:0] tmr_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] tvld_reg;

    logic [ADDR_W-1:0]  addr_reg;
    logic               func_reg;
    logic [ADDR_W-1:0]  key_rd_reg;
    logic [TIMER_W-1:0] tmr_rd_reg;
    logic               vld_rd_reg;
    logic [TIMER_W-1:0] tv;

    logic               found_reg, found_next;
    logic [IW-1:0]      hit_idx_reg, hit_idx_next;
    logic [TIMER_W-1:0] hit_tmr_reg, hit_tmr_next;
    logic [TIMER_W-1:0] min_reg, min_next;
    logic [IW-1:0]      vic_reg, vic_next;
    logic               hit;

    logic               wr_en, key_we;
    logic [IW-1:0]      wr_idx;
    logic [TIMER_W-1:0] wr_tmr;

    logic               out_vld_reg;
    logic [TIMER_W-1:0] out_tmr_reg;
    logic               out_blk_reg;

    assign tv  = vld_rd_reg ? tmr_rd_reg : '0;
    assign hit = (tv != '0) && (key_rd_reg == addr_reg);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            addr_reg <= s_tdata;
            func_reg <= s_tuser;
        end
    end

    always_comb begin
        found_next   = found_reg;
        hit_idx_next = hit_idx_reg;
        hit_tmr_next = hit_tmr_reg;
        min_next     = min_reg;
        vic_next     = vic_reg;
        if (cmd.ev_en && (func_reg == FUNC_LOOKUP)) begin
            if (cmd.ev_first) begin
                found_next = hit;
                min_next   = tv;
                vic_next   = ev_idx;
            end else if (tv < min_reg) begin
                min_next = tv;
                vic_next = ev_idx;
            end
            if (hit && (cmd.ev_first || !found_reg)) begin
                found_next   = 1'b1;
                hit_idx_next = ev_idx;
                hit_tmr_next = tv;
            end
        end
    end

    always_ff @(posedge aclk) begin
        found_reg   <= found_next;
        hit_idx_reg <= hit_idx_next;
        hit_tmr_reg <= hit_tmr_next;
        min_reg     <= min_next;
        vic_reg     <= vic_next;
    end

    always_comb begin
        wr_en  = 1'b0;
        key_we = 1'b0;
        wr_idx = ev_idx;
        wr_tmr = tv - 1'b1;
        if (cmd.commit) begin
            wr_en  = 1'b1;
            wr_tmr = block_ticks;
            if (found_reg) begin
                wr_idx = hit_idx_reg;
            end else begin
                wr_idx = vic_reg;
                key_we = 1'b1;
            end
        end else if (cmd.ev_en && (func_reg == FUNC_TICK) && (tv != '0)) begin
            wr_en = 1'b1;
        end
    end

    // table storage, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tmr_mem[wr_idx] <= wr_tmr;
        end
        if (key_we) begin
            key_mem[wr_idx] <= addr_reg;
        end
        if (cmd.rd_en) begin
            key_rd_reg <= key_mem[rd_idx];
            tmr_rd_reg <= tmr_mem[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tvld_reg <= '0;
        end else if (wr_en) begin
            tvld_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            vld_rd_reg <= tvld_reg[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_tmr_reg <= found_reg ? hit_tmr_reg : '0;
            out_blk_reg <= found_reg;
        end
    end

    assign sts.is_lookup = (func_reg == FUNC_LOOKUP);
    assign sts.out_free  = !out_vld_reg || m_tready;
    assign m_tvalid      = out_vld_reg;
    assign m_tdata       = {{(OUT_DW - TIMER_W - 1){1'b0}}, out_blk_reg, out_tmr_reg};

endmodule

>>> rtl/aging_address_block_table.sv
// A lookup returns its result on m_tdata once its scan and its commit step are done; a tick gives no result.
// Each word is scanned one entry per cycle through the single table read port, and the next word
// is accepted only after that scan (and, for a lookup, its commit step) has finished.
// A result waiting on m_tready does not stop the next word from being accepted;
// a following lookup holds in its commit step until the result register frees.
// Reset (synchronous, aresetn low): all entries empty, block_ticks = 600, no result pending.
module aging_address_block_table
    import aabt_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 16
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [ADDR_W-1:0]   s_tdata,   // addr_high [63:0], addr_low [127:64]
    input  logic                s_tuser,   // func

    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_DW-1:0]   m_tdata,   // remaining_ticks [15:0], was_blocked [16]

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CFG_AW-1:0]   paddr,
    input  logic [CFG_DW-1:0]   pwdata,
    output logic [CFG_DW-1:0]   prdata,
    output logic                pready
);

    localparam int unsigned IW = $clog2(TABLE_ENTRIES);

    logic [TIMER_W-1:0] block_ticks_reg;
    logic               cfg_we;
    cmd_t               cmd;
    sts_t               sts;
    logic [IW-1:0]      rd_idx;
    logic [IW-1:0]      ev_idx;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_BLOCK_TICKS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_ticks_reg <= BLOCK_TICKS_RST;
        end else if (cfg_we) begin
            block_ticks_reg <= pwdata[TIMER_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_BLOCK_TICKS) ?
                    {{(CFG_DW - TIMER_W){1'b0}}, block_ticks_reg} : '0;

    aabt_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd),
        .rd_idx   (rd_idx),
        .ev_idx   (ev_idx)
    );

    aabt_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .block_ticks (block_ticks_reg),
        .cmd         (cmd),
        .rd_idx      (rd_idx),
        .ev_idx      (ev_idx),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule
